// File: hdl/ethernet_ip_flow_key_parser_core_macros.svh
// Assertion macros for the flow-key parser.
// Included by the top level; depends on nothing else.
`ifndef ETHERNET_IP_FLOW_KEY_PARSER_CORE_MACROS_SVH
`define ETHERNET_IP_FLOW_KEY_PARSER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EFKP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("flow-key parser assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define EFKP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("flow-key parser assertion failed");

`endif

// File: hdl/efkp_pkg.sv
// Shared types, constants and helper functions of the flow-key parser.
// Used by the channel interfaces and the top level; depends on nothing.
package efkp_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] half_type;
   typedef logic [63:0] addr_word_type;

   localparam half_type MAX_FRAME_LEN = 16'hFFFF;

   localparam half_type ETYPE_VLAN = 16'h8100;
   localparam half_type ETYPE_QINQ = 16'h88A8;
   localparam half_type ETYPE_IPV4 = 16'h0800;
   localparam half_type ETYPE_IPV6 = 16'h86DD;

   localparam byte_type PROTO_TCP = 8'd6;
   localparam byte_type PROTO_UDP = 8'd17;

   localparam logic [5:0] TCP_HDR_LEN   = 6'd20;
   localparam logic [5:0] UDP_HDR_LEN   = 6'd8;
   localparam logic [3:0] IHL_MIN       = 4'd5;
   localparam logic [1:0] MAX_TAGS      = 2'd2;
   localparam half_type   ETYPE_POS_HI  = 16'd12;
   localparam half_type   ETYPE_POS_LO  = 16'd13;

   typedef enum logic [2:0] {
      PH_ETH  = 3'd0,
      PH_TAG  = 3'd1,
      PH_V4   = 3'd2,
      PH_V6   = 3'd3,
      PH_L4   = 3'd4,
      PH_FAIL = 3'd5,
      PH_DONE = 3'd6
   } phase_type;

   typedef struct packed {
      logic          parse_ok;
      logic          ip_family;
      byte_type      ip_protocol;
      addr_word_type src_addr_hi;
      addr_word_type src_addr_lo;
      addr_word_type dst_addr_hi;
      addr_word_type dst_addr_lo;
      half_type      sport;
      half_type      dport;
      half_type      l3_offset;
      half_type      l3_length;
   } result_type;

   function automatic logic is_tag(input half_type etype);
      return (etype == ETYPE_VLAN) || (etype == ETYPE_QINQ);
   endfunction

   function automatic phase_type l3_phase(input half_type etype);
      phase_type ph;
      if (etype == ETYPE_IPV4) begin
         ph = PH_V4;
      end else if (etype == ETYPE_IPV6) begin
         ph = PH_V6;
      end else begin
         ph = PH_FAIL;
      end
      return ph;
   endfunction

endpackage

// File: hdl/efkp_channels.sv
// Valid/ready channel interfaces for frame bytes and flow-key results.
// Depends on efkp_pkg for the payload types.
interface efkp_req_if
   import efkp_pkg::*;
   ();
   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface efkp_rsp_if
   import efkp_pkg::*;
   ();
   logic          valid;
   logic          ready;
   logic          parse_ok;
   logic          ip_family;
   byte_type      ip_protocol;
   addr_word_type src_addr_hi;
   addr_word_type src_addr_lo;
   addr_word_type dst_addr_hi;
   addr_word_type dst_addr_lo;
   half_type      sport;
   half_type      dport;
   half_type      l3_offset;
   half_type      l3_length;

   modport source (output valid, output parse_ok, output ip_family, output ip_protocol,
                   output src_addr_hi, output src_addr_lo, output dst_addr_hi,
                   output dst_addr_lo, output sport, output dport,
                   output l3_offset, output l3_length, input ready);
   modport sink   (input valid, input parse_ok, input ip_family, input ip_protocol,
                   input src_addr_hi, input src_addr_lo, input dst_addr_hi,
                   input dst_addr_lo, input sport, input dport,
                   input l3_offset, input l3_length, output ready);
endinterface

// File: hdl/ethernet_ip_flow_key_parser_core.sv
// Streaming Ethernet/IPv4/IPv6 flow-key parser, top level.
// Depends on efkp_pkg, the channel interfaces and the assertion macro header.
//
//   Channel   Direction  Carries                               Word
//   req_ch    in         data_byte, last_byte                  one frame byte
//   rsp_ch    out        parse_ok ... l3_length (flow key)     one key per frame
//
// One byte is taken every cycle while req_ch.ready is high; its parse state
// is updated at the edge it is accepted, which for the last byte also registers the key.
// The result side has an output register and a skid register, so req_ch.ready only
// drops while both hold a key; it comes from a register, not from rsp_ch.ready.
// Synchronous reset clears all parse state and the valid flags of both result registers.
`include "ethernet_ip_flow_key_parser_core_macros.svh"

module ethernet_ip_flow_key_parser_core
   import efkp_pkg::*;
   (
   input logic        clock,
   input logic        reset,
   efkp_req_if.sink   req_ch,
   efkp_rsp_if.source rsp_ch
   );

   half_type       byte_count_ff, byte_count_in;
   phase_type      phase_ff, phase_in;
   half_type       etype_ff, etype_in;
   logic [1:0]     tags_ff, tags_in;
   half_type       ip_start_ff, ip_start_in;
   logic [16:0]    l4_start_ff, l4_start_in;
   logic [5:0]     hdr_cnt_ff, hdr_cnt_in;
   addr_word_type  addr_ff [4];
   addr_word_type  addr_in [4];
   half_type       port_ff [2];
   half_type       port_in [2];
   byte_type       proto_ff, proto_in;
   logic           family_ff, family_in;

   result_type     out_ff, skid_ff, key_in;
   logic           out_valid_ff, skid_valid_ff;

   logic           accept;
   logic           emit;

   assign req_ch.ready = !skid_valid_ff;
   assign accept       = req_ch.valid && req_ch.ready;
   assign emit         = accept && req_ch.last_byte;

   always_comb begin
      half_type    pos;
      half_type    pos_next;
      half_type    rel;
      logic [5:0]  rel6;
      logic [1:0]  widx;
      logic        ports_ok;
      logic        key_ok;
      byte_type    din;

      pos      = byte_count_ff;
      pos_next = byte_count_ff + 16'd1;
      rel      = byte_count_ff - ip_start_ff;
      rel6     = rel[5:0] - 6'd8;
      widx     = rel6[4:3];
      din      = req_ch.data_byte;

      byte_count_in = byte_count_ff;
      phase_in      = phase_ff;
      etype_in      = etype_ff;
      tags_in       = tags_ff;
      ip_start_in   = ip_start_ff;
      l4_start_in   = l4_start_ff;
      hdr_cnt_in    = hdr_cnt_ff;
      addr_in       = addr_ff;
      port_in       = port_ff;
      proto_in      = proto_ff;
      family_in     = family_ff;

      if (byte_count_ff < MAX_FRAME_LEN) begin
         byte_count_in = pos_next;
         unique case (phase_ff)
            PH_ETH: begin
               if (pos >= ETYPE_POS_HI) begin
                  etype_in = {etype_ff[7:0], din};
               end
               if (pos == ETYPE_POS_LO) begin
                  if (is_tag(etype_in)) begin
                     phase_in   = PH_TAG;
                     hdr_cnt_in = '0;
                  end else begin
                     ip_start_in = pos_next;
                     hdr_cnt_in  = '0;
                     phase_in    = l3_phase(etype_in);
                     family_in   = (etype_in == ETYPE_IPV6);
                  end
               end
            end
            PH_TAG: begin
               if (hdr_cnt_ff >= 6'd2) begin
                  etype_in = {etype_ff[7:0], din};
               end
               if (hdr_cnt_ff == 6'd3) begin
                  tags_in = tags_ff + 2'd1;
                  if (is_tag(etype_in) && (tags_in < MAX_TAGS)) begin
                     hdr_cnt_in = '0;
                  end else begin
                     ip_start_in = pos_next;
                     hdr_cnt_in  = '0;
                     phase_in    = l3_phase(etype_in);
                     family_in   = (etype_in == ETYPE_IPV6);
                  end
               end else begin
                  hdr_cnt_in = hdr_cnt_ff + 6'd1;
               end
            end
            PH_V4: begin
               if ((rel == 16'd0) && (din[3:0] < IHL_MIN)) begin
                  phase_in = PH_FAIL;
               end else begin
                  if (rel == 16'd0) begin
                     l4_start_in = {1'b0, ip_start_ff} + {11'd0, din[3:0], 2'b00};
                  end else if (rel == 16'd9) begin
                     proto_in = din;
                  end else if ((rel >= 16'd12) && (rel < 16'd16)) begin
                     addr_in[1] = {addr_ff[1][55:0], din};
                  end else if ((rel >= 16'd16) && (rel < 16'd20)) begin
                     addr_in[3] = {addr_ff[3][55:0], din};
                  end
                  // The header ends once the byte after this one is the transport start.
                  if ({1'b0, pos_next} == l4_start_in) begin
                     phase_in   = PH_L4;
                     hdr_cnt_in = '0;
                  end
               end
            end
            PH_V6: begin
               if (rel == 16'd6) begin
                  proto_in = din;
               end else if ((rel >= 16'd8) && (rel < 16'd40)) begin
                  addr_in[widx] = {addr_ff[widx][55:0], din};
               end
               if (rel == 16'd39) begin
                  l4_start_in = {1'b0, pos_next};
                  phase_in    = PH_L4;
                  hdr_cnt_in  = '0;
               end
            end
            PH_L4: begin
               if (hdr_cnt_ff < 6'd4) begin
                  port_in[hdr_cnt_ff[1]] = {port_ff[hdr_cnt_ff[1]][7:0], din};
               end
               hdr_cnt_in = hdr_cnt_ff + 6'd1;
               if (hdr_cnt_in >= TCP_HDR_LEN) begin
                  phase_in = PH_DONE;
               end
            end
            PH_FAIL, PH_DONE: begin
            end
            default: begin
            end
         endcase
      end

      // The key is built from the state as it stands after this byte.
      key_ok   = (phase_in == PH_L4) || (phase_in == PH_DONE);
      ports_ok = ((proto_in == PROTO_TCP) && (hdr_cnt_in >= TCP_HDR_LEN)) ||
                 ((proto_in == PROTO_UDP) && (hdr_cnt_in >= UDP_HDR_LEN));
      key_in = '0;
      if (key_ok) begin
         key_in.parse_ok    = 1'b1;
         key_in.ip_family   = family_in;
         key_in.ip_protocol = proto_in;
         key_in.src_addr_hi = addr_in[0];
         key_in.src_addr_lo = addr_in[1];
         key_in.dst_addr_hi = addr_in[2];
         key_in.dst_addr_lo = addr_in[3];
         if (ports_ok) begin
            key_in.sport = port_in[0];
            key_in.dport = port_in[1];
         end
         key_in.l3_offset = ip_start_in;
         key_in.l3_length = byte_count_in - ip_start_in;
      end

      // The last byte of a frame leaves clean state for the next one.
      if (req_ch.last_byte) begin
         byte_count_in = '0;
         phase_in      = PH_ETH;
         etype_in      = '0;
         tags_in       = '0;
         ip_start_in   = '0;
         l4_start_in   = '0;
         hdr_cnt_in    = '0;
         addr_in       = '{default: '0};
         port_in       = '{default: '0};
         proto_in      = '0;
         family_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         phase_ff      <= PH_ETH;
         etype_ff      <= '0;
         tags_ff       <= '0;
         ip_start_ff   <= '0;
         l4_start_ff   <= '0;
         hdr_cnt_ff    <= '0;
         addr_ff       <= '{default: '0};
         port_ff       <= '{default: '0};
         proto_ff      <= '0;
         family_ff     <= 1'b0;
      end else if (accept) begin
         byte_count_ff <= byte_count_in;
         phase_ff      <= phase_in;
         etype_ff      <= etype_in;
         tags_ff       <= tags_in;
         ip_start_ff   <= ip_start_in;
         l4_start_ff   <= l4_start_in;
         hdr_cnt_ff    <= hdr_cnt_in;
         addr_ff       <= addr_in;
         port_ff       <= port_in;
         proto_ff      <= proto_in;
         family_ff     <= family_in;
      end
   end

   // Output register with a skid stage behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ch.ready) begin
         if (skid_valid_ff) begin
            out_ff        <= skid_ff;
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else if (emit) begin
            out_ff       <= key_in;
            out_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end else if (emit) begin
         skid_ff       <= key_in;
         skid_valid_ff <= 1'b1;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.parse_ok    = out_ff.parse_ok;
   assign rsp_ch.ip_family   = out_ff.ip_family;
   assign rsp_ch.ip_protocol = out_ff.ip_protocol;
   assign rsp_ch.src_addr_hi = out_ff.src_addr_hi;
   assign rsp_ch.src_addr_lo = out_ff.src_addr_lo;
   assign rsp_ch.dst_addr_hi = out_ff.dst_addr_hi;
   assign rsp_ch.dst_addr_lo = out_ff.dst_addr_lo;
   assign rsp_ch.sport       = out_ff.sport;
   assign rsp_ch.dport       = out_ff.dport;
   assign rsp_ch.l3_offset   = out_ff.l3_offset;
   assign rsp_ch.l3_length   = out_ff.l3_length;

   // A key can only wait in the skid register behind one in the output register.
   `EFKP_ASSERT_SAME(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)

   // A failed parse zeroes all other fields; checked on low addresses, sport and l3 fields.
   `EFKP_ASSERT_SAME(a_fail_key_zero, clock, reset, out_valid_ff && !out_ff.parse_ok,
      (out_ff.src_addr_lo == '0) && (out_ff.dst_addr_lo == '0) && (out_ff.sport == '0) &&
      (out_ff.l3_offset == '0) && (out_ff.l3_length == '0))

   // The word after a frame's last byte starts from a clean Ethernet header.
   `EFKP_ASSERT_NEXT(a_frame_restart, clock, reset, emit,
      (phase_ff == PH_ETH) && (byte_count_ff == '0) && (tags_ff == '0))

endmodule
